/* rtl/clipped_bitmap_blit_address_gen_core_macros.svh */
// Assertion helpers for the core RTL file, which carries the checks.
// Each macro expects clk and rst in the scope where it is used.
`ifndef CLIPPED_BITMAP_BLIT_ADDRESS_GEN_CORE_MACROS_SVH
`define CLIPPED_BITMAP_BLIT_ADDRESS_GEN_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CBB_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CBB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/cbb_pkg.sv */
`default_nettype none

package cbb_pkg;

  // Screen size in pixels
  localparam int SCREEN_WIDTH  = 240;
  localparam int SCREEN_HEIGHT = 320;

  // Signed working width for clip arithmetic
  localparam int CW = 13;
  localparam logic signed [CW-1:0] SW = CW'(SCREEN_WIDTH);
  localparam logic signed [CW-1:0] SH = CW'(SCREEN_HEIGHT);

  // Operation codes of the input word
  localparam logic OP_START = 1'b0;
  localparam logic OP_NEXT  = 1'b1;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_ACCEPT = 2'd0,
    KIND_REJECT = 2'd1,
    KIND_PIXEL  = 2'd2,
    KIND_IDLE   = 2'd3
  } kind_t;

  // Decoded command held in the queue
  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_REJECT = 2'd1,
    CMD_NEXT   = 2'd2
  } cmd_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [8:0]  win_x0;
    logic [8:0]  win_y0;
    logic [8:0]  win_x1;
    logic [8:0]  win_y1;
    logic [9:0]  clip_w;
    logic [9:0]  clip_h;
    logic [9:0]  skip;
    logic [9:0]  stored_w;
    logic [16:0] index;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

/* rtl/cbb_if.sv */
`default_nettype none

// Input word channel
interface cbb_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic signed [10:0] left_x;
  logic signed [10:0] bottom_y;
  logic [9:0]         bitmap_width;
  logic [9:0]         bitmap_height;

  modport source (output valid, operation, left_x, bottom_y, bitmap_width,
                  bitmap_height, input ready);
  modport sink (input valid, operation, left_x, bottom_y, bitmap_width,
                bitmap_height, output ready);
endinterface

// Result word channel
interface cbb_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [8:0]  win_x0;
  logic [8:0]  win_y0;
  logic [8:0]  win_x1;
  logic [8:0]  win_y1;
  logic [16:0] pixel_index;
  logic        last;

  modport source (output valid, kind, win_x0, win_y0, win_x1, win_y1,
                  pixel_index, last, input ready);
  modport sink (input valid, kind, win_x0, win_y0, win_x1, win_y1,
                pixel_index, last, output ready);
endinterface

`default_nettype wire

/* rtl/cbb_front.sv */
`default_nettype none

module cbb_front
  import cbb_pkg::*;
(
  cbb_in_if.sink     req,
  input  q_status_t  q_stat,
  output logic       push,
  output entry_t     entry
);

  logic signed [CW-1:0] x, y, w, h, bot;
  logic signed [CW-1:0] wc, hc, skip, yc, x0, y0, x1;
  logic                 reject;
  logic [9:0]           mult_b;
  logic [19:0]          prod;
  logic [16:0]          x_ext;

  // Accept while the queue has room
  assign req.ready = !q_stat.full;
  assign push      = req.valid && req.ready;

  // Sign/zero extend to working width
  assign x   = {{(CW-11){req.left_x[10]}}, req.left_x};
  assign y   = {{(CW-11){req.bottom_y[10]}}, req.bottom_y};
  assign w   = {{(CW-10){1'b0}}, req.bitmap_width};
  assign h   = {{(CW-10){1'b0}}, req.bitmap_height};
  assign bot = y - h + CW'(1);

  // Rejection: empty, off screen, or larger than the screen
  assign reject = (w == '0) || (h == '0) || (x >= SW) || (bot >= SH) ||
                  ((x + w) <= CW'(0)) || (y < CW'(0)) || (w > SW) || (h > SH);

  // Clip to the screen
  always_comb begin
    wc   = w;
    skip = '0;
    hc   = h;
    yc   = y;
    if ((x + w - CW'(1)) >= SW) begin
      skip = x + w - SW;
      wc   = SW - x;
    end
    if (x < CW'(0)) begin
      wc   = wc + x;
      skip = -x;
    end
    if (bot < CW'(0)) begin
      hc = y + CW'(1);
    end
    if (y >= SH) begin
      hc = hc - (y - SH + CW'(1));
      yc = SH - CW'(1);
    end
  end

  assign x0 = (x < CW'(0)) ? '0 : x;
  assign y0 = yc - hc + CW'(1);
  assign x1 = x0 + wc - CW'(1);

  // Start index: width times the store row of the top visible row,
  // moved right past columns clipped on the left
  assign mult_b = (bot < CW'(0)) ? y[9:0] : (h[9:0] - 10'd1);
  assign prod   = req.bitmap_width * mult_b;
  assign x_ext  = {{(17-CW){x[CW-1]}}, x};

  always_comb begin
    entry          = '0;
    entry.win_x0   = x0[8:0];
    entry.win_y0   = y0[8:0];
    entry.win_x1   = x1[8:0];
    entry.win_y1   = yc[8:0];
    entry.clip_w   = wc[9:0];
    entry.clip_h   = hc[9:0];
    entry.skip     = skip[9:0];
    entry.stored_w = req.bitmap_width;
    entry.index    = (x < CW'(0)) ? (prod[16:0] - x_ext) : prod[16:0];
    if (req.operation == OP_NEXT) begin
      entry.cmd = CMD_NEXT;
    end else if (reject) begin
      entry.cmd = CMD_REJECT;
    end else begin
      entry.cmd = CMD_START;
    end
  end

endmodule

`default_nettype wire

/* rtl/cbb_queue.sv */
`default_nettype none

module cbb_queue
  import cbb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  entry_t     wr_data,
  input  logic       pop,
  output entry_t     rd_data,
  output q_status_t  stat
);

  entry_t     slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign stat.full  = (count == 2'd2);
  assign stat.empty = (count == 2'd0);
  assign rd_data    = slots[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

`default_nettype wire

/* rtl/cbb_back.sv */
`default_nettype none

module cbb_back
  import cbb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  entry_t     head,
  input  q_status_t  q_stat,
  output logic       pop,
  cbb_out_if.source  rsp
);

  // Walk state
  logic        active, active_next;
  logic [16:0] src, src_next;
  logic [9:0]  col, col_next;
  logic [9:0]  row, row_next;
  logic [9:0]  cw, cw_next;
  logic [9:0]  ch, ch_next;
  logic [9:0]  skip, skip_next;
  logic [9:0]  sw, sw_next;

  // Output register
  logic        out_valid;
  kind_t       kind, kind_next;
  logic [8:0]  x0, y0, x1, y1;
  logic [8:0]  x0_next, y0_next, x1_next, y1_next;
  logic [16:0] pix, pix_next;
  logic        last, last_next;

  logic end_row, end_all;

  assign pop = !q_stat.empty && (!out_valid || rsp.ready);

  assign end_row = ({1'b0, col} + 11'd1) >= {1'b0, cw};
  assign end_all = end_row && (({1'b0, row} + 11'd1) >= {1'b0, ch});

  // Execute the head command
  always_comb begin
    active_next = active;
    src_next    = src;
    col_next    = col;
    row_next    = row;
    cw_next     = cw;
    ch_next     = ch;
    skip_next   = skip;
    sw_next     = sw;
    kind_next   = KIND_IDLE;
    x0_next     = '0;
    y0_next     = '0;
    x1_next     = '0;
    y1_next     = '0;
    pix_next    = '0;
    last_next   = 1'b0;
    unique case (head.cmd)
      CMD_START: begin
        active_next = 1'b1;
        src_next    = head.index;
        col_next    = '0;
        row_next    = '0;
        cw_next     = head.clip_w;
        ch_next     = head.clip_h;
        skip_next   = head.skip;
        sw_next     = head.stored_w;
        kind_next   = KIND_ACCEPT;
        x0_next     = head.win_x0;
        y0_next     = head.win_y0;
        x1_next     = head.win_x1;
        y1_next     = head.win_y1;
      end
      CMD_REJECT: begin
        active_next = 1'b0;
        kind_next   = KIND_REJECT;
      end
      CMD_NEXT: begin
        if (active) begin
          kind_next = KIND_PIXEL;
          pix_next  = src;
          last_next = end_all;
          if (end_all) begin
            active_next = 1'b0;
          end else if (end_row) begin
            col_next = '0;
            row_next = row + 10'd1;
            src_next = src + 17'd1 + {7'b0, skip} - {6'b0, sw, 1'b0};
          end else begin
            col_next = col + 10'd1;
            src_next = src + 17'd1;
          end
        end
      end
      default: begin
        kind_next = KIND_IDLE;
      end
    endcase
  end

  // Walk state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      src    <= '0;
      col    <= '0;
      row    <= '0;
      cw     <= '0;
      ch     <= '0;
      skip   <= '0;
      sw     <= '0;
    end else if (pop) begin
      active <= active_next;
      src    <= src_next;
      col    <= col_next;
      row    <= row_next;
      cw     <= cw_next;
      ch     <= ch_next;
      skip   <= skip_next;
      sw     <= sw_next;
    end
  end

  // Result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (pop) begin
      kind <= kind_next;
      x0   <= x0_next;
      y0   <= y0_next;
      x1   <= x1_next;
      y1   <= y1_next;
      pix  <= pix_next;
      last <= last_next;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.kind        = kind;
  assign rsp.win_x0      = x0;
  assign rsp.win_y0      = y0;
  assign rsp.win_x1      = x1;
  assign rsp.win_y1      = y1;
  assign rsp.pixel_index = pix;
  assign rsp.last        = last;

endmodule

`default_nettype wire

/* rtl/clipped_bitmap_blit_address_gen_core.sv */
// Clipped bitmap blit address generator.
// req carries words: operation 0 starts a bitmap (left_x, bottom_y, width,
// height), operation 1 asks for the next source pixel index.
// rsp returns exactly one word per request, in order: window accepted with
// the clipped corners, rejected, a pixel index with last on the final one,
// or nothing active.
// On its way to rsp a result word is registered in the two-entry queue
// and then in the output register: the front classifies and clips in the
// accepting cycle and writes the queue, and the pixel walker registers the
// result when it pops the entry, which waits while rsp holds a stalled word.
// Throughput is one word per cycle while rsp is ready, start and next alike.
// When rsp stalls, the output register holds its word and the queue takes
// up to two more words before req.ready drops.
// Synchronous reset empties the queue, drops rsp.valid and ends any blit.
`default_nettype none

`include "clipped_bitmap_blit_address_gen_core_macros.svh"

module clipped_bitmap_blit_address_gen_core
  import cbb_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  cbb_in_if.sink  req,
  cbb_out_if.source rsp
);

  entry_t    in_entry;
  entry_t    head;
  logic      push;
  logic      pop;
  q_status_t q_stat;

  logic      accept_word;
  logic      other_word;
  logic      corners_ok;
  logic      pixel_clear;

  cbb_front u_front (
    .req    (req),
    .q_stat (q_stat),
    .push   (push),
    .entry  (in_entry)
  );

  cbb_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (in_entry),
    .pop     (pop),
    .rd_data (head),
    .stat    (q_stat)
  );

  cbb_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .rsp    (rsp)
  );

  // Check terms
  assign accept_word = rsp.valid && (rsp.kind == KIND_ACCEPT);
  assign other_word  = rsp.valid && (rsp.kind != KIND_PIXEL);
  assign corners_ok  = (rsp.win_x0 <= rsp.win_x1) && (rsp.win_y0 <= rsp.win_y1);
  assign pixel_clear = !rsp.last && (rsp.pixel_index == '0);

  // Checks
  `CBB_ASSERT_NEXT(a_push_lands, push, !q_stat.empty, "accepted word lost from queue")
  `CBB_ASSERT_SAME(a_window_order, accept_word, corners_ok, "window corners out of order")
  `CBB_ASSERT_SAME(a_nonpixel_clean, other_word, pixel_clear, "pixel fields on non-pixel word")

endmodule

`default_nettype wire
